// ----- rtl/core/ppd_pkg.sv -----
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants for the pedal press detector
// Holds field widths, register reset values, register indexes, the
// controller state encoding and the command and status bundles.
// ----------------------------------------------------------------------------
package ppd_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int TRIG_W   = 8;
    localparam int TIME_W   = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Default oversample limit per update
    localparam int MAX_OVERSAMPLE_DEF = 16;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(1000);
    localparam logic [TRIG_W-1:0]   TRIGGER_RST   = TRIG_W'(3);
    localparam logic [TIME_W-1:0]   REARM_RST     = TIME_W'(500);

    // Register indexes (byte address is four times the index)
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_TRIGGER   = 2'd1,
        REG_REARM     = 2'd2,
        REG_ENABLE    = 2'd3
    } reg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Configuration register bundle
    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold_mv;
        logic [TRIG_W-1:0]   trigger_count;
        logic [TIME_W-1:0]   rearm_delay;
        logic                pedal_enable;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_step;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic in_good;
        logic div_last;
        logic out_free;
        logic den_zero;
    } status_t;

endpackage

// ----- rtl/core/pedal_press_detector.sv -----
// ----------------------------------------------------------------------------
// pedal_press_detector: oversampled pedal threshold detector with debounce
// Averages the good ADC attempts of each update, debounces the level against
// a threshold and clears the press latch after a rearm delay.
// ----------------------------------------------------------------------------
// Sequence: a non-closing attempt only enters the accumulator; a closing
// attempt with good samples runs the one-bit-per-cycle restoring divider on
// SUM_W bits (16 at the default limit), then finishes; others go to finish.
// Throughput: one attempt in flight at a time; the result register lets the
// next attempt enter while a transaction waits on the result channel.
// Reset: synchronous active-low; registers return to defaults, state clears.
module pedal_press_detector
    import ppd_pkg::*;
#(
    parameter int MAX_OVERSAMPLE = MAX_OVERSAMPLE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Attempt channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample_mv,
    input  logic                  s_sample_ok,
    input  logic                  s_last_attempt,
    input  logic [TIME_W-1:0]     s_now_ms,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SAMPLE_W-1:0]   m_level_mv,
    output logic                  m_pressed,
    output logic                  m_rearmed,
    output logic                  m_signal_lost
);

    cfg_t     cfg;
    cmd_t     cmd;
    status_t  sts;
    reg_idx_t reg_idx;
    logic     cfg_write;

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [TRIG_W-1:0]   trigger_reg;
    logic [TIME_W-1:0]   rearm_reg;
    logic                pedal_enable_reg;

    // Register file write
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RST;
            trigger_reg      <= TRIGGER_RST;
            rearm_reg        <= REARM_RST;
            pedal_enable_reg <= 1'b0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_THRESHOLD: threshold_reg    <= pwdata[SAMPLE_W-1:0];
                REG_TRIGGER:   trigger_reg      <= pwdata[TRIG_W-1:0];
                REG_REARM:     rearm_reg        <= pwdata[TIME_W-1:0];
                REG_ENABLE:    pedal_enable_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register file read
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            REG_TRIGGER:   prdata = APB_DATA_W'(trigger_reg);
            REG_REARM:     prdata = APB_DATA_W'(rearm_reg);
            REG_ENABLE:    prdata = APB_DATA_W'(pedal_enable_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.threshold_mv  = threshold_reg;
        cfg.trigger_count = trigger_reg;
        cfg.rearm_delay   = rearm_reg;
        cfg.pedal_enable  = pedal_enable_reg;
    end

    // Controller
    ppd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_ready)
    );

    // Datapath
    ppd_datapath #(
        .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg          (cfg),
        .in_valid     (s_valid),
        .sample_mv    (s_sample_mv),
        .sample_ok    (s_sample_ok),
        .last_attempt (s_last_attempt),
        .now_ms       (s_now_ms),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .level_mv     (m_level_mv),
        .pressed      (m_pressed),
        .rearmed      (m_rearmed),
        .signal_lost  (m_signal_lost)
    );

    // The divider never runs with a zero divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !sts.den_zero)
        else $error("divider stepping with zero divisor");

    // A closing transaction holds off further attempts in the cycle after it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_attempt |=> !s_ready)
        else $error("attempt accepted while an update is closing");

    // Finishing an update always presents a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("finished update produced no result");

    // Only one command is issued at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.div_step, cmd.finish}))
        else $error("conflicting controller commands");

endmodule

// ----- rtl/core/ppd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppd_ctrl: sequencing controller for the pedal press detector
// Accepts attempts while idle, runs the serial divider for a closing
// attempt with good samples, then waits for the result register to free up.
// ----------------------------------------------------------------------------
module ppd_ctrl
    import ppd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t sts,
    output cmd_t    cmd,
    output logic    in_ready
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = sts.in_valid;
                if (sts.in_valid && sts.in_last) begin
                    state_next = sts.in_good ? ST_DIVIDE : ST_FINISH;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/ppd_datapath.sv -----
// ----------------------------------------------------------------------------
// ppd_datapath: accumulator, serial divider, debounce and result register
// Sums good samples of one update, averages them with a restoring
// divider one quotient bit per cycle, and updates the press state.
// ----------------------------------------------------------------------------
module ppd_datapath
    import ppd_pkg::*;
#(
    parameter int MAX_OVERSAMPLE = MAX_OVERSAMPLE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             sts,
    input  cfg_t                cfg,
    input  logic                in_valid,
    input  logic [SAMPLE_W-1:0] sample_mv,
    input  logic                sample_ok,
    input  logic                last_attempt,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] level_mv,
    output logic                pressed,
    output logic                rearmed,
    output logic                signal_lost
);

    localparam int CNT_W  = $clog2(MAX_OVERSAMPLE + 1);
    localparam int SUM_W  = $clog2(((2 ** SAMPLE_W) - 1) * MAX_OVERSAMPLE + 1);
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_OVERSAMPLE);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    // Partial update accumulation
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    cnt_next;
    logic                take_sample;

    // Divider and closing context
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    den_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                good_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [CNT_W:0]      rem_shift;
    logic                rem_ge;
    logic [CNT_W:0]      rem_diff;

    // Debounce state
    logic [SAMPLE_W-1:0] level_reg;
    logic [TRIG_W-1:0]   above_reg;
    logic                latch_reg;
    logic [TIME_W-1:0]   since_reg;
    logic [SAMPLE_W-1:0] level_next;
    logic [TRIG_W-1:0]   above_next;
    logic                latch_next;
    logic [TIME_W-1:0]   since_next;
    logic [TIME_W-1:0]   since_start;
    logic [TIME_W-1:0]   elapsed;
    logic [TRIG_W-1:0]   above_inc;

    // Result register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] level_mv_reg;
    logic                pressed_reg;
    logic                rearmed_reg;
    logic                lost_reg;

    // Sample accumulation
    assign take_sample = cfg.pedal_enable && sample_ok && (cnt_reg < CNT_MAX);
    assign sum_next    = take_sample ? sum_reg + SUM_W'(sample_mv) : sum_reg;
    assign cnt_next    = take_sample ? cnt_reg + CNT_W'(1) : cnt_reg;

    // Status to the controller
    always_comb begin
        sts.in_valid = in_valid;
        sts.in_last  = last_attempt;
        sts.in_good  = cfg.pedal_enable && (cnt_next != '0);
        sts.div_last = (step_reg == STEP_LAST);
        sts.out_free = !out_valid_reg || out_ready;
        sts.den_zero = (den_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.accept) begin
            if (last_attempt || !cfg.pedal_enable) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Restoring division step
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.accept && last_attempt) begin
            step_reg <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && last_attempt) begin
            quo_reg  <= sum_next;
            rem_reg  <= '0;
            den_reg  <= cnt_next;
            good_reg <= cfg.pedal_enable && (cnt_next != '0);
            now_reg  <= now_ms;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    // Closing update of the debounce state
    assign above_inc   = (above_reg < cfg.trigger_count) ? above_reg + TRIG_W'(1)
                                                         : above_reg;
    assign since_start = (latch_reg && since_reg == '0) ? now_reg : since_reg;
    assign elapsed     = now_reg - since_start;

    always_comb begin
        level_next = level_reg;
        above_next = above_reg;
        latch_next = latch_reg;
        since_next = since_reg;
        if (good_reg) begin
            level_next = quo_reg[SAMPLE_W-1:0];
            if (level_next >= cfg.threshold_mv) begin
                above_next = above_inc;
                if (above_inc >= cfg.trigger_count) begin
                    latch_next = 1'b1;
                    since_next = '0;
                end
            end else begin
                above_next = '0;
                since_next = since_start;
                if (since_start != '0 && elapsed >= cfg.rearm_delay) begin
                    latch_next = 1'b0;
                    since_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            above_reg <= '0;
            latch_reg <= 1'b0;
            since_reg <= '0;
        end else if (cmd.finish) begin
            level_reg <= level_next;
            above_reg <= above_next;
            latch_reg <= latch_next;
            since_reg <= since_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            level_mv_reg <= level_next;
            pressed_reg  <= cfg.pedal_enable && (above_next >= cfg.trigger_count);
            rearmed_reg  <= !cfg.pedal_enable ||
                            ((level_next < cfg.threshold_mv) && !latch_next);
            lost_reg     <= cfg.pedal_enable && !good_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level_mv    = level_mv_reg;
    assign pressed     = pressed_reg;
    assign rearmed     = rearmed_reg;
    assign signal_lost = lost_reg;

endmodule
